// File: sv/qau_pkg.sv
package qau_pkg;

    // Default component width, Q2.(width-2) fixed point.
    localparam int QAU_CW_DEF = 16;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_NORM = 2'd1,
        OP_MAT  = 2'd2
    } t_op;

    localparam logic [1:0] ROW_LAST = 2'd2;

endpackage

// File: sv/qau_norm.sv
// Normalizer datapath: a pipelined digit-by-digit square root of the sum of
// squares (one root bit per stage), then four restoring dividers in parallel
// (one quotient bit per stage). All stages advance only when i_en is high.
module qau_norm
    import qau_pkg::*;
#(
    parameter int CW = QAU_CW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2*CW:0]        i_sum,
    input  logic [3:0][CW-1:0]   i_mag,
    input  logic [3:0]           i_neg,
    output logic [3:0][CW-1:0]   o_res,
    output logic                 o_sat
);

    localparam int FRAC = CW - 2;
    localparam int NSQ  = CW + 1;
    localparam int NB   = 2 * NSQ;
    localparam int RW   = CW + 3;
    localparam int NW   = 2 * CW;

    typedef struct packed {
        logic [NB-1:0]       n;
        logic [RW-1:0]       rem;
        logic [CW:0]         root;
        logic [3:0][CW-1:0]  mag;
        logic [3:0]          neg;
    } t_sq;

    typedef struct packed {
        logic [3:0][CW:0]    rem;
        logic [3:0][CW-1:0]  low;
        logic [3:0][CW-1:0]  quo;
        logic [CW:0]         m;
        logic [3:0]          neg;
    } t_dv;

    t_sq r_sq [NSQ];
    t_sq n_sq [NSQ];
    t_dv r_dv [CW];
    t_dv n_dv [CW];

    function automatic t_sq sq_step(input t_sq s);
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic          ge;
        t_sq           o;
        begin
            o     = s;
            cur   = {s.rem, s.n[NB-1:NB-2]};
            trial = (RW+2)'({s.root, 2'b01});
            ge    = (cur >= trial);
            o.rem  = ge ? RW'(cur - trial) : RW'(cur);
            o.root = {s.root[CW-1:0], ge};
            o.n    = {s.n[NB-3:0], 2'b00};
            return o;
        end
    endfunction

    function automatic t_dv dv_step(input t_dv d);
        logic [CW+1:0] cur;
        logic          ge;
        t_dv           o;
        begin
            o = d;
            for (int k = 0; k < 4; k++) begin
                cur = {d.rem[k], d.low[k][CW-1]};
                ge  = (cur >= (CW+2)'(d.m));
                o.rem[k] = ge ? (CW+1)'(cur - (CW+2)'(d.m)) : (CW+1)'(cur);
                o.low[k] = {d.low[k][CW-2:0], 1'b0};
                o.quo[k] = {d.quo[k][CW-2:0], ge};
            end
            return o;
        end
    endfunction

    always_comb begin
        t_sq        s0;
        t_dv        d0;
        logic [NW-1:0] num;
        s0.n    = NB'(i_sum);
        s0.rem  = '0;
        s0.root = '0;
        s0.mag  = i_mag;
        s0.neg  = i_neg;
        n_sq[0] = sq_step(s0);
        for (int k = 1; k < NSQ; k++) begin
            n_sq[k] = sq_step(r_sq[k-1]);
        end
        // Rounded quotient: (mag * 2^FRAC + m/2) / m. The magnitude never
        // exceeds the root, so the upper half is always below the divisor.
        d0.m   = r_sq[NSQ-1].root;
        d0.neg = r_sq[NSQ-1].neg;
        for (int k = 0; k < 4; k++) begin
            num = (NW'(r_sq[NSQ-1].mag[k]) << FRAC) + NW'(r_sq[NSQ-1].root[CW:1]);
            d0.rem[k] = {1'b0, num[NW-1:CW]};
            d0.low[k] = num[CW-1:0];
            d0.quo[k] = '0;
        end
        n_dv[0] = dv_step(d0);
        for (int k = 1; k < CW; k++) begin
            n_dv[k] = dv_step(r_dv[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
            r_dv <= n_dv;
        end
    end

    always_comb begin
        logic [CW-1:0] q;
        logic [CW-1:0] lim;
        q     = '0;
        lim   = '0;
        o_sat = 1'b0;
        o_res = '0;
        if (r_dv[CW-1].m == '0) begin
            o_res[0] = CW'(1) << FRAC;
        end else begin
            for (int k = 0; k < 4; k++) begin
                q   = r_dv[CW-1].quo[k];
                lim = r_dv[CW-1].neg[k] ? (CW'(1) << (CW-1)) : ((CW'(1) << (CW-1)) - CW'(1));
                if (q > lim) begin
                    q     = lim;
                    o_sat = 1'b1;
                end
                o_res[k] = r_dv[CW-1].neg[k] ? CW'(-q) : q;
            end
        end
    end

endmodule

// File: sv/quaternion_arith_unit.sv
// Channel   | Direction | Ports                      | Beat contents
// ----------+-----------+----------------------------+--------------------------------------
// request   | in        | i_s_tvalid/o_s_tready      | tdata: a_w,a_x,a_y,a_z,b_w,b_x,b_y,b_z
//           |           |                            | tuser: req_type
// result    | out       | o_m_tvalid/i_m_tready      | tdata: res0..res3, tuser: row_index,
//           |           |                            | saturated; tlast: last
//
// Multiply and normalize requests are taken one per cycle unless the result side
// stalls; a to-matrix request holds the input while its rows are issued, one row
// a cycle unless stalled. Every beat passes through a delay line matched to the
// square root and divider stages. Reset clears only the valid bits and the row
// counter. A stall on the result side freezes the whole pipeline; nothing is lost.
module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int CW = QAU_CW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [8*CW-1:0]               i_s_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [1:0]                    i_s_tuser,  // req_type
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [((4*CW+7)/8)*8-1:0]     o_m_tdata,  // res0, res1, res2, res3
    output logic [2:0]                    o_m_tuser,  // row_index, saturated
    output logic                          o_m_tlast
);

    localparam int FRAC = CW - 2;
    localparam int PW   = 2 * CW;
    localparam int SW   = 2 * CW + 4;
    localparam int ODW  = ((4*CW+7)/8)*8;
    localparam int NQ   = 2 * CW + 1;
    localparam logic [SW-1:0] ONE2 = SW'(1) << (2*FRAC);
    localparam logic [SW-1:0] HALF = SW'(1) << (FRAC-1);

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [1:0]  row;
    } t_tok;

    typedef struct packed {
        t_tok                tok;
        logic                sat;
        logic [3:0][CW-1:0]  res;
    } t_res;

    logic en;
    logic accept;
    logic issue_done;

    // Input hold stage.
    logic                 r_in_valid;
    logic [1:0]           r_in_op;
    logic [1:0]           r_row;
    logic [3:0][CW-1:0]   r_in_a;
    logic [3:0][CW-1:0]   r_in_b;

    // Product stage.
    t_tok                       r_tok1;
    logic signed [PW-1:0]       r_p [16];
    logic [3:0][CW-1:0]         r_mag1;
    logic [3:0]                 r_neg1;

    // Sum stage.
    t_tok                       r_tok2;
    logic signed [SW-1:0]       r_e [4];
    logic [2*CW:0]              r_sum2;
    logic [3:0][CW-1:0]         r_mag2;
    logic [3:0]                 r_neg2;

    t_res                       r_d [NQ];
    t_res                       n_d0;

    logic                       r_out_valid;
    logic [3:0][CW-1:0]         r_out_res;
    logic [1:0]                 r_out_row;
    logic                       r_out_sat;
    logic                       r_out_last;

    logic signed [PW-1:0]       n_p [16];
    logic signed [SW-1:0]       n_e [4];
    logic [2*CW:0]              n_sum;
    logic [3:0][CW-1:0]         n_mag;
    logic [3:0]                 n_neg;
    logic [3:0][CW-1:0]         norm_res;
    logic                       norm_sat;

    assign en         = !r_out_valid || i_m_tready;
    assign issue_done = (r_in_op != OP_MAT) || (r_row == ROW_LAST);
    assign o_s_tready = !r_in_valid || (en && issue_done);
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_row      <= '0;
        end else if (accept) begin
            // Unused operation codes are taken and dropped here.
            r_in_valid <= (i_s_tuser == OP_MUL) || (i_s_tuser == OP_NORM)
                          || (i_s_tuser == OP_MAT);
            r_row      <= '0;
        end else if (en && r_in_valid) begin
            if (issue_done) begin
                r_in_valid <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op <= i_s_tuser;
            for (int k = 0; k < 4; k++) begin
                r_in_a[k] <= i_s_tdata[k*CW +: CW];
                r_in_b[k] <= i_s_tdata[(k+4)*CW +: CW];
            end
        end
    end

    // Product stage: every a_i times b_j, or a_i times a_j when B is unused.
    always_comb begin
        logic signed [CW-1:0] av;
        logic signed [CW-1:0] bv;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                av = r_in_a[i];
                bv = (r_in_op == OP_MUL) ? r_in_b[j] : r_in_a[j];
                n_p[i*4+j] = av * bv;
            end
            n_neg[i] = r_in_a[i][CW-1];
            n_mag[i] = r_in_a[i][CW-1] ? CW'(-r_in_a[i]) : r_in_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1.valid <= 1'b0;
        end else if (en) begin
            r_tok1.valid <= r_in_valid;
            r_tok1.op    <= r_in_op;
            r_tok1.row   <= r_row;
            r_p          <= n_p;
            r_mag1       <= n_mag;
            r_neg1       <= n_neg;
        end
    end

    // Sum stage. Index pairs: w=0, x=1, y=2, z=3, product (i,j) at i*4+j.
    always_comb begin
        logic signed [SW-1:0] pe [16];
        logic signed [SW-1:0] sq;
        for (int k = 0; k < 16; k++) begin
            pe[k] = SW'(r_p[k]);
        end
        sq    = pe[0] + pe[5] + pe[10] + pe[15];
        n_sum = sq[2*CW:0];
        n_e[0] = '0;
        n_e[1] = '0;
        n_e[2] = '0;
        n_e[3] = '0;
        unique case (r_tok1.op)
            OP_MUL: begin
                n_e[0] = pe[0] - pe[5] - pe[10] - pe[15];
                n_e[1] = pe[1] + pe[4] + pe[11] - pe[14];
                n_e[2] = pe[2] - pe[7] + pe[8] + pe[13];
                n_e[3] = pe[3] + pe[6] - pe[9] + pe[12];
            end
            OP_MAT: begin
                unique case (r_tok1.row)
                    2'd0: begin
                        n_e[0] = ONE2 - ((pe[10] + pe[15]) <<< 1);
                        n_e[1] = (pe[6] - pe[12]) <<< 1;
                        n_e[2] = (pe[7] + pe[8]) <<< 1;
                    end
                    2'd1: begin
                        n_e[0] = (pe[6] + pe[12]) <<< 1;
                        n_e[1] = ONE2 - ((pe[5] + pe[15]) <<< 1);
                        n_e[2] = (pe[11] - pe[4]) <<< 1;
                    end
                    default: begin
                        n_e[0] = (pe[7] - pe[8]) <<< 1;
                        n_e[1] = (pe[11] + pe[4]) <<< 1;
                        n_e[2] = ONE2 - ((pe[5] + pe[10]) <<< 1);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok2.valid <= 1'b0;
        end else if (en) begin
            r_tok2.valid <= r_tok1.valid;
            r_tok2.op    <= r_tok1.op;
            r_tok2.row   <= r_tok1.row;
            r_e          <= n_e;
            r_sum2       <= n_sum;
            r_mag2       <= r_mag1;
            r_neg2       <= r_neg1;
        end
    end

    // Round half up to FRAC bits, then clip to the component range.
    always_comb begin
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] sh;
        n_d0.tok = r_tok2;
        n_d0.sat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            v  = r_e[k] + HALF;
            sh = v >>> FRAC;
            if ((&sh[SW-1:CW-1]) || !(|sh[SW-1:CW-1])) begin
                n_d0.res[k] = sh[CW-1:0];
            end else begin
                n_d0.sat    = 1'b1;
                n_d0.res[k] = v[SW-1] ? (CW'(1) << (CW-1)) : ((CW'(1) << (CW-1)) - CW'(1));
            end
        end
    end

    qau_norm #(
        .CW (CW)
    ) u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum2),
        .i_mag  (r_mag2),
        .i_neg  (r_neg2),
        .o_res  (norm_res),
        .o_sat  (norm_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NQ; k++) begin
                r_d[k].tok.valid <= 1'b0;
            end
        end else if (en) begin
            r_d[0].tok.valid <= n_d0.tok.valid;
            r_d[0].tok.op    <= n_d0.tok.op;
            r_d[0].tok.row   <= n_d0.tok.row;
            r_d[0].sat       <= n_d0.sat;
            r_d[0].res       <= n_d0.res;
            for (int k = 1; k < NQ; k++) begin
                r_d[k].tok.valid <= r_d[k-1].tok.valid;
                r_d[k].tok.op    <= r_d[k-1].tok.op;
                r_d[k].tok.row   <= r_d[k-1].tok.row;
                r_d[k].sat       <= r_d[k-1].sat;
                r_d[k].res       <= r_d[k-1].res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d[NQ-1].tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_d[NQ-1].tok.op == OP_NORM) begin
                r_out_res <= norm_res;
                r_out_sat <= norm_sat;
            end else begin
                r_out_res <= r_d[NQ-1].res;
                r_out_sat <= r_d[NQ-1].sat;
            end
            r_out_row  <= (r_d[NQ-1].tok.op == OP_MAT) ? r_d[NQ-1].tok.row : 2'd0;
            r_out_last <= (r_d[NQ-1].tok.op != OP_MAT) || (r_d[NQ-1].tok.row == ROW_LAST);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ODW'(r_out_res);
    assign o_m_tuser  = {r_out_sat, r_out_row};
    assign o_m_tlast  = r_out_last;

endmodule

// File: tb/sv/qau_checker.sv
`timescale 1ns / 100ps

module qau_checker
    import qau_pkg::*;
#(
    parameter int CW = QAU_CW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [8*CW-1:0]           i_s_tdata,
    input  logic [1:0]                i_s_tuser,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [((4*CW+7)/8)*8-1:0] i_m_tdata,
    input  logic [2:0]                i_m_tuser,
    input  logic                      i_m_tlast,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int FRAC = CW - 2;

    typedef struct packed {
        logic [CW-1:0] r0;
        logic [CW-1:0] r1;
        logic [CW-1:0] r2;
        logic [CW-1:0] r3;
        logic [1:0]    row;
        logic          sat;
        logic          last;
    } t_beat;

    t_beat expected_beats[$];

    assign o_pending = expected_beats.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // Rounds an exact sum (scaled by 2^FRAC twice) to one component and clips it.
    function automatic logic [CW-1:0] round_clip(input logic signed [127:0] acc,
                                                  inout logic sat);
        logic signed [127:0] v;
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        v = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        hi_lim = (128'sd1 <<< (CW - 1)) - 1;
        lo_lim = -(128'sd1 <<< (CW - 1));
        if (v > hi_lim) begin
            sat = 1'b1;
            v = hi_lim;
        end else if (v < lo_lim) begin
            sat = 1'b1;
            v = lo_lim;
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [127:0] sx(input logic [CW-1:0] c);
        logic signed [CW-1:0] s;
        s = c;
        return 128'(s);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] b;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= n) r = b;
        end
        return r[63:0];
    endfunction

    task automatic predict_request(input logic [1:0] op, input logic [8*CW-1:0] d);
        logic signed [127:0] aw, ax, ay, az, bw, bx, by, bz;
        logic signed [127:0] e0, e1, e2, one2;
        logic [127:0] ssq, m, mag, q, lim;
        logic [CW-1:0] comp[4];
        logic signed [127:0] av[4];
        t_beat b;
        aw = sx(d[0*CW +: CW]); ax = sx(d[1*CW +: CW]);
        ay = sx(d[2*CW +: CW]); az = sx(d[3*CW +: CW]);
        bw = sx(d[4*CW +: CW]); bx = sx(d[5*CW +: CW]);
        by = sx(d[6*CW +: CW]); bz = sx(d[7*CW +: CW]);
        b = '0;
        case (op)
            OP_MUL: begin
                b.r0 = round_clip(aw*bw - ax*bx - ay*by - az*bz, b.sat);
                b.r1 = round_clip(aw*bx + ax*bw + ay*bz - az*by, b.sat);
                b.r2 = round_clip(aw*by - ax*bz + ay*bw + az*bx, b.sat);
                b.r3 = round_clip(aw*bz + ax*by - ay*bx + az*bw, b.sat);
                b.last = 1'b1;
                expected_beats.push_back(b);
            end
            OP_NORM: begin
                av[0] = aw; av[1] = ax; av[2] = ay; av[3] = az;
                ssq = aw*aw + ax*ax + ay*ay + az*az;
                m = int_sqrt(ssq);
                if (m == 0) begin
                    b.r0 = CW'(1) << FRAC;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        mag = (av[k] < 0) ? -av[k] : av[k];
                        q = ((mag << FRAC) + (m >> 1)) / m;
                        lim = (av[k] < 0) ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
                        if (q > lim) begin
                            q = lim;
                            b.sat = 1'b1;
                        end
                        comp[k] = (av[k] < 0) ? CW'(-q) : CW'(q);
                    end
                    b.r0 = comp[0]; b.r1 = comp[1]; b.r2 = comp[2]; b.r3 = comp[3];
                end
                b.last = 1'b1;
                expected_beats.push_back(b);
            end
            OP_MAT: begin
                one2 = 128'sd1 <<< (2 * FRAC);
                for (int r = 0; r < 3; r++) begin
                    if (r == 0) begin
                        e0 = one2 - 2*(ay*ay + az*az);
                        e1 = 2*(ax*ay - az*aw);
                        e2 = 2*(ax*az + ay*aw);
                    end else if (r == 1) begin
                        e0 = 2*(ax*ay + az*aw);
                        e1 = one2 - 2*(ax*ax + az*az);
                        e2 = 2*(ay*az - ax*aw);
                    end else begin
                        e0 = 2*(ax*az - ay*aw);
                        e1 = 2*(ay*az + ax*aw);
                        e2 = one2 - 2*(ax*ax + ay*ay);
                    end
                    b = '0;
                    b.r0 = round_clip(e0, b.sat);
                    b.r1 = round_clip(e1, b.sat);
                    b.r2 = round_clip(e2, b.sat);
                    b.row = 2'(r);
                    b.last = (2'(r) == ROW_LAST);
                    expected_beats.push_back(b);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            predict_request(i_s_tuser, i_s_tdata);
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (expected_beats.size() == 0) begin
                report("unexpected result beat", 1, 0);
            end else begin
                want = expected_beats.pop_front();
                if (i_m_tdata[0*CW +: CW] !== want.r0)
                    report("res0", i_m_tdata[0*CW +: CW], want.r0);
                if (i_m_tdata[1*CW +: CW] !== want.r1)
                    report("res1", i_m_tdata[1*CW +: CW], want.r1);
                if (i_m_tdata[2*CW +: CW] !== want.r2)
                    report("res2", i_m_tdata[2*CW +: CW], want.r2);
                if (i_m_tdata[3*CW +: CW] !== want.r3)
                    report("res3", i_m_tdata[3*CW +: CW], want.r3);
                if (i_m_tuser[1:0] !== want.row) report("row_index", i_m_tuser[1:0], want.row);
                if (i_m_tuser[2] !== want.sat) report("saturated", i_m_tuser[2], want.sat);
                if (i_m_tlast !== want.last) report("last", i_m_tlast, want.last);
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qau_pkg::*;

    localparam int CW = QAU_CW_DEF;
    localparam int OW = ((4*CW+7)/8)*8;
    localparam int LATENCY = 2*CW + 5;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [8*CW-1:0] i_s_tdata;
    logic [1:0]      i_s_tuser;
    logic            o_m_tvalid;
    logic            i_m_tready;
    logic [OW-1:0]   o_m_tdata;
    logic [2:0]      o_m_tuser;
    logic            o_m_tlast;
    int              errors;
    int              pending;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    bit  hold_req;

    quaternion_arith_unit #(.CW(CW)) dut (.*);

    qau_checker #(.CW(CW)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver: random stalls, plus a long hold-off requested by the stimulus.
    always @(negedge i_clk) begin
        if (hold_off)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        hold_off = 1'b1;
        wait (i_rst_n);
        hold_off = 1'b0;
        wait (hold_req);
        hold_off = 1'b1;
        repeat (200) @(negedge i_clk);
        hold_off = 1'b0;
    end

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(9))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '0;
            3, 4, 5: return CW'($urandom_range(1 << (CW - 2)) - (1 << (CW - 3)));
            default: return CW'($urandom);
        endcase
    endfunction

    // Leaves tvalid high after the beat; the next call replaces or drops it, or the caller drops it.
    task automatic send_beat(input logic [1:0] op, input logic [8*CW-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [8*CW-1:0] d;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 8; k++) d[k*CW +: CW] = rand_comp();
            op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
            send_beat(op, d);
        end
    endtask

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] CONE = CW'(1) << (CW - 2);

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = OP_MUL;
        send_idle_pct = 30;
        recv_idle_pct = 80;
        hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, identity, zero magnitude, every operation.
        send_beat(OP_MUL,  {CONE, {3{CW'(0)}}, {3{CW'(0)}}, CONE});
        send_beat(OP_MUL,  {{4{CMAX}}, {4{CMAX}}});
        send_beat(OP_MUL,  {{4{CMIN}}, {4{CMIN}}});
        send_beat(OP_MUL,  {{4{CMIN}}, {4{CMAX}}});
        send_beat(OP_MUL,  {{4{CW'(16'h5555)}}, {4{CW'(16'hAAAA)}}});
        send_beat(OP_NORM, '0);
        send_beat(OP_NORM, {{4{CMAX}}, {4{CMIN}}});
        send_beat(OP_NORM, {{4{CMIN}}, {4{CMAX}}});
        send_beat(OP_NORM, {{4{CMAX}}, CW'(0), CW'(0), CW'(0), CW'(1)});
        send_beat(OP_NORM, {{4{CMAX}}, CW'(0), CW'(0), CW'(0), CMIN});
        send_beat(OP_MAT,  {{4{CMAX}}, {3{CW'(0)}}, CONE});
        send_beat(OP_MAT,  {{4{CMAX}}, {4{CMAX}}});
        send_beat(OP_MAT,  {{4{CMAX}}, {4{CMIN}}});
        send_beat(OP_MAT,  '0);
        send_beat(OP_UNUSED, {8{CMAX}});

        send_random(30);
        send_idle_pct = 80;
        recv_idle_pct = 30;
        send_random(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_random(40);
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("quaternion_arith_unit verification clean");
        else
            $display("quaternion_arith_unit verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("quaternion_arith_unit verification failed");
        $finish;
    end

endmodule
